// ----- hw/rtl/bpps_pkg.sv -----
// Shared types and constants for the breath phase PWM sequencer.
// Holds the register map, the configuration and scaled-value structs and the phase codes.
// No dependencies; every other file of the block imports this package.
package bpps_pkg;

    // Field widths
    localparam int KNOB_W    = 10;
    localparam int DUTY_W    = 8;
    localparam int PHASE_W   = 3;
    localparam int INSP_W    = 12;
    localparam int EXPI_W    = 13;
    localparam int ELAPSED_W = 14;

    // Configuration port geometry
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DRIVE_FIRST_INSP = 3'd0;
    localparam logic [2:0] REG_DRIVE_FIRST_EXP  = 3'd1;
    localparam logic [2:0] REG_DRIVE_SECOND_EXP = 3'd2;
    localparam logic [2:0] REG_DRIVE_FLOOR      = 3'd3;
    localparam logic [2:0] REG_DRIVE_CEILING    = 3'd4;
    localparam logic [2:0] REG_FIRST_INSP_MS    = 3'd5;
    localparam logic [2:0] REG_FIRST_EXP_MS     = 3'd6;

    // Knob scaling: min + span * knob / 1024
    localparam int INSP_MIN_MS  = 1000;
    localparam int INSP_SPAN_MS = 3000;
    localparam int EXP_MIN_MS   = 1000;
    localparam int EXP_SPAN_MS  = 5000;
    localparam int INSP_PROD_W  = 22;
    localparam int EXP_PROD_W   = 23;

    // Elapsed-time counter value after reset
    localparam logic [ELAPSED_W-1:0] ELAPSED_RST = 14'd100;

    // Breath phase codes as they appear on the result channel
    typedef enum logic [PHASE_W-1:0] {
        PH_I0   = 3'd0,
        PH_I1   = 3'd1,
        PH_E0   = 3'd2,
        PH_E1   = 3'd3,
        PH_IDLE = 3'd4
    } phase_t;

    typedef struct packed {
        logic [DUTY_W-1:0] drive_first_insp;
        logic [DUTY_W-1:0] drive_first_exp;
        logic [DUTY_W-1:0] drive_second_exp;
        logic [DUTY_W-1:0] drive_floor;
        logic [DUTY_W-1:0] drive_ceiling;
        logic [INSP_W-1:0] first_insp_ms;
        logic [EXPI_W-1:0] first_exp_ms;
    } cfg_t;

    localparam cfg_t CFG_RST = '{
        drive_first_insp: 8'd255,
        drive_first_exp:  8'd63,
        drive_second_exp: 8'd63,
        drive_floor:      8'd0,
        drive_ceiling:    8'd255,
        first_insp_ms:    12'd200,
        first_exp_ms:     13'd1000
    };

    // Per-item values derived from the knobs
    typedef struct packed {
        logic [DUTY_W-1:0] i1_duty;
        logic [INSP_W-1:0] insp_ms;
        logic [EXPI_W-1:0] exp_ms;
    } scaled_t;

endpackage

// ----- hw/rtl/bpps_cfg_regs.sv -----
// Configuration register file with an APB-style write/read port.
// Depends on bpps_pkg for the register map and the cfg_t struct.
module bpps_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpps_pkg::CFG_AW-1:0]  paddr,
    input  logic [bpps_pkg::CFG_DW-1:0]  pwdata,
    output logic [bpps_pkg::CFG_DW-1:0]  prdata,
    output bpps_pkg::cfg_t               cfg
);
    import bpps_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    // Merge a write into the register set; unknown indexes drop the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_DRIVE_FIRST_INSP: cfg_next.drive_first_insp = pwdata[DUTY_W-1:0];
                REG_DRIVE_FIRST_EXP:  cfg_next.drive_first_exp  = pwdata[DUTY_W-1:0];
                REG_DRIVE_SECOND_EXP: cfg_next.drive_second_exp = pwdata[DUTY_W-1:0];
                REG_DRIVE_FLOOR:      cfg_next.drive_floor      = pwdata[DUTY_W-1:0];
                REG_DRIVE_CEILING:    cfg_next.drive_ceiling    = pwdata[DUTY_W-1:0];
                REG_FIRST_INSP_MS:    cfg_next.first_insp_ms    = pwdata[INSP_W-1:0];
                REG_FIRST_EXP_MS:     cfg_next.first_exp_ms     = pwdata[EXPI_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register, zero-extended
    always_comb
    begin
        unique case (reg_idx)
            REG_DRIVE_FIRST_INSP: prdata = CFG_DW'(cfg_reg.drive_first_insp);
            REG_DRIVE_FIRST_EXP:  prdata = CFG_DW'(cfg_reg.drive_first_exp);
            REG_DRIVE_SECOND_EXP: prdata = CFG_DW'(cfg_reg.drive_second_exp);
            REG_DRIVE_FLOOR:      prdata = CFG_DW'(cfg_reg.drive_floor);
            REG_DRIVE_CEILING:    prdata = CFG_DW'(cfg_reg.drive_ceiling);
            REG_FIRST_INSP_MS:    prdata = CFG_DW'(cfg_reg.first_insp_ms);
            REG_FIRST_EXP_MS:     prdata = CFG_DW'(cfg_reg.first_exp_ms);
            default:              prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/bpps_scaler.sv -----
// Input stage: scales the three knob readings and holds them in the input register.
// Depends on bpps_pkg for widths, scaling constants and the cfg_t/scaled_t structs.
module bpps_scaler
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,    // [9:0] knob_power, [19:10] knob_insp_time,
                                          // [29:20] knob_exp_time, [31:30] zero
    input  bpps_pkg::cfg_t    cfg,
    input  logic              core_ready,
    output logic              stage_valid,
    output bpps_pkg::scaled_t stage_data
);
    import bpps_pkg::*;

    logic [KNOB_W-1:0]        knob_power;
    logic [KNOB_W-1:0]        knob_insp_time;
    logic [KNOB_W-1:0]        knob_exp_time;
    logic signed [8:0]        duty_span;
    logic signed [19:0]       duty_prod;
    logic signed [19:0]       duty_bias;
    logic signed [19:0]       duty_quot;
    logic [INSP_PROD_W-1:0]   insp_prod;
    logic [EXP_PROD_W-1:0]    exp_prod;
    scaled_t                  scaled;
    logic                     accept;
    logic                     valid_reg;
    logic                     valid_next;
    scaled_t                  data_reg;
    scaled_t                  data_next;

    assign knob_power     = s_tdata[KNOB_W-1:0];
    assign knob_insp_time = s_tdata[2*KNOB_W-1:KNOB_W];
    assign knob_exp_time  = s_tdata[3*KNOB_W-1:2*KNOB_W];

    // I1 duty: floor + (ceiling - floor) * knob / 1024, truncated toward zero
    assign duty_span = $signed({1'b0, cfg.drive_ceiling}) - $signed({1'b0, cfg.drive_floor});
    assign duty_prod = 20'(duty_span) * 20'($signed({1'b0, knob_power}));
    assign duty_bias = duty_prod[19] ? (duty_prod + 20'sd1023) : duty_prod;
    assign duty_quot = duty_bias >>> KNOB_W;

    // Time limits: min + span * knob / 1024
    assign insp_prod = INSP_PROD_W'(INSP_SPAN_MS) * INSP_PROD_W'(knob_insp_time);
    assign exp_prod  = EXP_PROD_W'(EXP_SPAN_MS) * EXP_PROD_W'(knob_exp_time);

    always_comb
    begin
        scaled.i1_duty = cfg.drive_floor + duty_quot[DUTY_W-1:0];
        scaled.insp_ms = INSP_W'(INSP_MIN_MS) + insp_prod[INSP_PROD_W-1:KNOB_W];
        scaled.exp_ms  = EXPI_W'(EXP_MIN_MS) + exp_prod[EXP_PROD_W-1:KNOB_W];
    end

    // Take a new item whenever the register is empty or drains this cycle
    assign s_tready = !valid_reg || core_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            data_next  = scaled;
        end
        else if (core_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

endmodule

// ----- hw/rtl/bpps_phase_core.sv -----
// Phase stage: advances the elapsed-time counter, picks the breath phase and duty,
// and holds them in the result register. Depends on bpps_pkg.
module bpps_phase_core
#(
    parameter int TICK_MS = 100
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bpps_pkg::scaled_t in_data,
    input  bpps_pkg::cfg_t    cfg,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_duty,
    output logic [2:0]        out_phase,
    output logic              out_inhaling,
    output logic              out_restart
);
    import bpps_pkg::*;

    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ELAPSED_W-1:0] elapsed_next;
    logic [DUTY_W-1:0]    duty_reg;
    logic [DUTY_W-1:0]    duty_next;
    phase_t               phase_reg;
    phase_t               phase_next;
    logic                 restart_reg;
    logic                 restart_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 fire;
    logic [ELAPSED_W-1:0] tick_time;
    logic [ELAPSED_W-1:0] e1_start;
    logic [ELAPSED_W-1:0] period;

    // The result register is free when empty or being taken this cycle
    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    assign tick_time = elapsed_reg + ELAPSED_W'(TICK_MS);
    assign e1_start  = ELAPSED_W'(in_data.insp_ms) + ELAPSED_W'(cfg.first_exp_ms);
    assign period    = ELAPSED_W'(in_data.insp_ms) + ELAPSED_W'(in_data.exp_ms);

    // Select the phase; the first limit not yet reached wins, past the period restart
    always_comb
    begin
        elapsed_next = elapsed_reg;
        duty_next    = duty_reg;
        phase_next   = phase_reg;
        restart_next = restart_reg;
        valid_next   = valid_reg;
        if (fire)
        begin
            valid_next   = 1'b1;
            elapsed_next = tick_time;
            restart_next = 1'b0;
            priority if (tick_time < ELAPSED_W'(cfg.first_insp_ms))
            begin
                phase_next = PH_I0;
                duty_next  = cfg.drive_first_insp;
            end
            else if (tick_time < ELAPSED_W'(in_data.insp_ms))
            begin
                phase_next = PH_I1;
                duty_next  = in_data.i1_duty;
            end
            else if (tick_time < e1_start)
            begin
                phase_next = PH_E0;
                duty_next  = cfg.drive_first_exp;
            end
            else if (tick_time < period)
            begin
                phase_next = PH_E1;
                duty_next  = cfg.drive_second_exp;
            end
            else
            begin
                elapsed_next = '0;
                restart_next = 1'b1;
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= ELAPSED_RST;
            duty_reg    <= '0;
            phase_reg   <= PH_IDLE;
            restart_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            duty_reg    <= duty_next;
            phase_reg   <= phase_next;
            restart_reg <= restart_next;
            valid_reg   <= valid_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_duty     = duty_reg;
    assign out_phase    = phase_reg;
    assign out_inhaling = (phase_reg == PH_I0) || (phase_reg == PH_I1);
    assign out_restart  = restart_reg;

endmodule

// ----- hw/rtl/breath_phase_pwm_sequencer_top.sv -----
// Top level of the breath phase PWM sequencer.
// Instantiates bpps_cfg_regs, bpps_scaler and bpps_phase_core; depends on bpps_pkg.
//
// Usage:
//   Each item on the s_ stream is one timer tick of TICK_MS milliseconds and carries
//   the three 10-bit knob readings. Each accepted item yields exactly one result on
//   the m_ stream: the PWM duty and breath phase held after the tick, the inhale
//   flag on m_tuser, and m_tlast high when the tick ended the breath period.
//   Registers are to be written over the APB-style port only while the block is
//   idle; the user must ensure this, as the block itself does not enforce it.
// Timing:
//   The knob scaling multipliers sit in front of the input register, the counter
//   and phase compares in front of the result register, which drives m_tvalid.
//   One item per cycle is sustained while m_tready is high. When m_tready is low,
//   the result register holds; the input register takes one more item only if it
//   is empty, and s_tready then stays low until the result is taken.
//
// Reset:
//   Registers return to their defaults, the elapsed counter to 100 ms, the duty
//   to 0 and the phase to "not yet started". No pending items survive reset.
module breath_phase_pwm_sequencer_top
#(
    parameter int TICK_MS = 100
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [9:0] knob_power, [19:10] knob_insp_time,
                                    // [29:20] knob_exp_time, [31:30] zero
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] pwm_duty, [10:8] phase, [15:11] zero
    output logic        m_tuser,    // [0] inhaling
    output logic        m_tlast,    // cycle_restart
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bpps_pkg::*;

    cfg_t              cfg;
    scaled_t           stage_data;
    logic              stage_valid;
    logic              core_ready;
    logic [DUTY_W-1:0] out_duty;
    logic [PHASE_W-1:0] out_phase;

    assign pready = 1'b1;

    bpps_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    bpps_scaler u_scaler
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg         (cfg),
        .core_ready  (core_ready),
        .stage_valid (stage_valid),
        .stage_data  (stage_data)
    );

    bpps_phase_core
    #(
        .TICK_MS (TICK_MS)
    )
    u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (stage_valid),
        .in_ready     (core_ready),
        .in_data      (stage_data),
        .cfg          (cfg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_duty     (out_duty),
        .out_phase    (out_phase),
        .out_inhaling (m_tuser),
        .out_restart  (m_tlast)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = {5'd0, out_phase, out_duty};

endmodule

// ----- hw/rtl/bpps_checker.sv -----
// Port-level checker for the breath phase PWM sequencer, bound to the top level.
// Depends on bpps_pkg for the phase codes.
module bpps_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    import bpps_pkg::*;

    // A stalled result keeps its payload
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // Inhale flag follows the reported phase
    a_inhale_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser == ((m_tdata[10:8] == PH_I0) || (m_tdata[10:8] == PH_I1)))
        else $error("inhale flag does not match phase");

    // Before the first phase is picked, the duty stays at zero
    a_idle_duty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[10:8] == PH_IDLE) |-> m_tdata[7:0] == 8'd0)
        else $error("nonzero duty before first phase");

    // Padding bits of the result stay clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:11] == 5'd0)
        else $error("result padding not zero");

endmodule

bind breath_phase_pwm_sequencer_top bpps_checker u_bpps_checker (.*);
